// File: rtl/ihex_pkg.sv
package ihex_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [0:0] REG_RECORD_MARK = 1'b0;

	localparam logic [7:0] MARK_RESET = 8'h3A;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [23:0] TOTAL_MAX = 24'hFF_FFFF;

	typedef enum logic [2:0] {
		KIND_DATA      = 3'd0,
		KIND_RECORD_OK = 3'd1,
		KIND_BAD_MARK  = 3'd2,
		KIND_CHECKSUM  = 3'd3,
		KIND_BAD_HEX   = 3'd4
	} kind_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

endpackage

// File: rtl/intel_hex_record_parser_core.sv
// Intel HEX record parser.
// Input stream s_axis: one text character per request in tdata[7:0].
// Output stream m_axis: at most one result per character. tuser carries the
// result kind (data byte, record ok, bad mark, checksum error, bad hex digit);
// tdata carries data byte, address, record type, byte count and the running
// total of committed type 0 data bytes.
// Characters are decoded as they are taken: the record state updates in the
// cycle a character is accepted and the result lands in the output register,
// so a result appears in the cycle after its character. One character per cycle
// is sustained while m_axis_tready stays high; the output register is the only stage between the sides.
// The record mark is set over the APB port (register 0, reset ':'); the user
// must write it only while the stream is idle, which the block does not enforce.
// Reset returns the parser to idle with base address and total cleared and
// the output empty. While the receiver holds m_axis_tready low with a result
// pending, s_axis_tready drops and no further character is taken.
module intel_hex_record_parser_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // char_in
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// data_byte[7:0], byte_address[39:8], record_type[47:40],
	// byte_count[55:48], total_data_bytes[79:56]
	output logic [79:0]                        m_axis_tdata,
	output logic [2:0]                         m_axis_tuser,  // result_kind
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ihex_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [ihex_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [ihex_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import ihex_pkg::*;

	logic [7:0]  record_mark;

	logic        in_record_q, in_record_d;
	logic [9:0]  char_index_q, char_index_d;
	logic [3:0]  high_nibble_q, high_nibble_d;
	logic [7:0]  length_q, length_d;
	logic [15:0] offset_q, offset_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  sum_q, sum_d;
	logic [31:0] data_shift_q, data_shift_d;
	logic [31:0] base_q, base_d;
	logic [31:0] rec_addr_q, rec_addr_d;
	logic [23:0] total_q, total_d;

	logic        out_valid_q;
	kind_t       out_kind_q;
	logic [7:0]  out_byte_q, out_type_q, out_count_q;
	logic [31:0] out_addr_q;
	logic [23:0] out_total_q;

	logic        accept;
	logic        emit;
	kind_t       kind;
	logic [7:0]  res_byte, res_type, res_count;
	logic [31:0] res_addr;

	logic [4:0]  nib;
	logic [7:0]  byte_val;
	logic [8:0]  pos;
	logic [8:0]  data_idx;
	logic [8:0]  data_end;
	logic [24:0] total_sum;

	ihex_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.record_mark (record_mark)
	);

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign nib       = hex_value(s_axis_tdata);
	assign byte_val  = {high_nibble_q, nib[3:0]};
	assign pos       = char_index_q[9:1];
	assign data_idx  = pos - 9'd4;
	assign data_end  = {1'b0, length_q} + 9'd4;
	assign total_sum = {1'b0, total_q} + {17'd0, length_q};

	always_comb begin
		in_record_d   = in_record_q;
		char_index_d  = char_index_q;
		high_nibble_d = high_nibble_q;
		length_d      = length_q;
		offset_d      = offset_q;
		type_d        = type_q;
		sum_d         = sum_q;
		data_shift_d  = data_shift_q;
		base_d        = base_q;
		rec_addr_d    = rec_addr_q;
		total_d       = total_q;
		emit          = 1'b0;
		kind          = KIND_DATA;
		res_byte      = '0;
		res_addr      = '0;
		res_type      = type_q;
		res_count     = length_q;

		if (!in_record_q) begin
			res_type  = '0;
			res_count = '0;
			if (s_axis_tdata == CHAR_LF || s_axis_tdata == CHAR_CR) begin
				// skipped
			end else if (s_axis_tdata == record_mark) begin
				in_record_d   = 1'b1;
				char_index_d  = '0;
				high_nibble_d = '0;
				length_d      = '0;
				offset_d      = '0;
				type_d        = '0;
				sum_d         = '0;
				data_shift_d  = '0;
			end else begin
				emit = 1'b1;
				kind = KIND_BAD_MARK;
			end
		end else if (nib[4]) begin
			emit        = 1'b1;
			kind        = KIND_BAD_HEX;
			in_record_d = 1'b0;
		end else if (!char_index_q[0]) begin
			high_nibble_d = nib[3:0];
			char_index_d  = char_index_q + 10'd1;
		end else begin
			char_index_d = char_index_q + 10'd1;
			sum_d        = sum_q + byte_val;
			if (pos == 9'd0) begin
				length_d = byte_val;
			end else if (pos <= 9'd2) begin
				offset_d = {offset_q[7:0], byte_val};
				// record address is fixed once the offset is complete
				rec_addr_d = base_q + {16'd0, offset_q[7:0], byte_val};
			end else if (pos == 9'd3) begin
				type_d = byte_val;
			end else if (pos < data_end) begin
				case (data_idx)
					9'd0:    data_shift_d = data_shift_q | {byte_val, 24'd0};
					9'd1:    data_shift_d = data_shift_q | {8'd0, byte_val, 16'd0};
					9'd2:    data_shift_d = data_shift_q | {16'd0, byte_val, 8'd0};
					9'd3:    data_shift_d = data_shift_q | {24'd0, byte_val};
					default: data_shift_d = data_shift_q;
				endcase
				if (type_q == 8'd0) begin
					emit     = 1'b1;
					kind     = KIND_DATA;
					res_byte = byte_val;
					res_addr = rec_addr_q + {23'd0, data_idx};
				end
			end else begin
				in_record_d = 1'b0;
				emit        = 1'b1;
				if (sum_d != 8'd0) begin
					kind = KIND_CHECKSUM;
				end else begin
					kind     = KIND_RECORD_OK;
					res_addr = rec_addr_q;
					if (type_q == 8'd4) begin
						base_d = {data_shift_q[31:16], 16'd0};
					end else if (type_q == 8'd5) begin
						base_d = data_shift_q;
					end else if (type_q == 8'd0) begin
						total_d = total_sum[24] ? TOTAL_MAX : total_sum[23:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_record_q   <= 1'b0;
			char_index_q  <= '0;
			high_nibble_q <= '0;
			length_q      <= '0;
			offset_q      <= '0;
			type_q        <= '0;
			sum_q         <= '0;
			data_shift_q  <= '0;
			base_q        <= '0;
			rec_addr_q    <= '0;
			total_q       <= '0;
		end else if (accept) begin
			in_record_q   <= in_record_d;
			char_index_q  <= char_index_d;
			high_nibble_q <= high_nibble_d;
			length_q      <= length_d;
			offset_q      <= offset_d;
			type_q        <= type_d;
			sum_q         <= sum_d;
			data_shift_q  <= data_shift_d;
			base_q        <= base_d;
			rec_addr_q    <= rec_addr_d;
			total_q       <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_kind_q  <= kind;
			out_byte_q  <= res_byte;
			out_addr_q  <= res_addr;
			out_type_q  <= res_type;
			out_count_q <= res_count;
			out_total_q <= total_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {out_total_q, out_count_q, out_type_q, out_addr_q, out_byte_q};

	a_data_type_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_DATA |-> out_type_q == 8'd0)
		else $error("data byte from a record whose type is not zero");

	a_bad_mark_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_BAD_MARK
		|-> out_type_q == 8'd0 && out_count_q == 8'd0 && out_addr_q == 32'd0)
		else $error("bad mark result carries record fields");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> total_q >= $past(total_q))
		else $error("committed total decreased");

	a_idle_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !in_record_q && emit |-> kind == KIND_BAD_MARK)
		else $error("idle parser produced a record result");

endmodule

// File: rtl/ihex_cfg.sv
module ihex_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ihex_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [ihex_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [ihex_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready,
	output logic [7:0]                         record_mark
);
	import ihex_pkg::*;

	logic [7:0] record_mark_q;
	logic       sel_mark;

	assign pready   = 1'b1;
	assign sel_mark = (paddr[2] == REG_RECORD_MARK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_mark_q <= MARK_RESET;
		end else if (psel && penable && pwrite && pready && sel_mark) begin
			record_mark_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_mark) begin
			prdata = {{(CFG_DATA_W-8){1'b0}}, record_mark_q};
		end
	end

	assign record_mark = record_mark_q;

endmodule
